### hdl/scs_pkg.sv
// shared types, constants and helpers of the synchronverter control step
package scs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OPW       = 34;   // multiplier operand width
  localparam int PRW       = 2 * OPW;
  localparam int ANG_SH    = 30 - FRAC_BITS;
  localparam int TM_SH     = 40;

  // raw constants, 32 fraction bits unless noted
  localparam logic [63:0] T_Q32      = 64'd429497;
  localparam logic [63:0] AP_Q32     = 64'd134930693;
  localparam logic [63:0] AQ_Q32     = 64'd67465346;
  localparam logic [63:0] COMP_Q32   = 64'd580024370;
  localparam logic [63:0] WN_Q32     = 64'd1349303770452;
  localparam logic [63:0] TWOPI_Q32  = 64'd26986075409;
  localparam logic [63:0] DQ_Q32     = 64'd186745178030;
  localparam logic [63:0] ONE_Q32    = 64'd4294967296;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWOPI_Q30  = 64'd6746518852;

  localparam logic [63:0] RND       = 64'd1 << (31 - FRAC_BITS);
  localparam logic [63:0] WN_F      = (WN_Q32 + RND) >> (32 - FRAC_BITS);
  localparam logic [63:0] TWOPI_F   = (TWOPI_Q32 + RND) >> (32 - FRAC_BITS);
  localparam logic [63:0] COMP_F    = (COMP_Q32 + RND) >> (32 - FRAC_BITS);
  localparam logic [63:0] DQ_F      = (DQ_Q32 + RND) >> (32 - FRAC_BITS);
  localparam logic [63:0] WMAX_F    = 64'd640 << FRAC_BITS;
  localparam logic [63:0] VNOM_F    = 64'd30 << FRAC_BITS;
  localparam logic [63:0] TM_RECIP  = (64'd1 << (TM_SH + FRAC_BITS)) / WN_F;

  // operand-sized signed views
  localparam logic signed [OPW-1:0] K_T     = OPW'(T_Q32);
  localparam logic signed [OPW-1:0] K_AP    = OPW'(AP_Q32);
  localparam logic signed [OPW-1:0] K_APC   = OPW'(ONE_Q32 - AP_Q32);
  localparam logic signed [OPW-1:0] K_AQ    = OPW'(AQ_Q32);
  localparam logic signed [OPW-1:0] K_AQC   = OPW'(ONE_Q32 - AQ_Q32);
  localparam logic signed [OPW-1:0] K_WN    = OPW'(WN_F);
  localparam logic signed [OPW-1:0] K_TWOPI = OPW'(TWOPI_F);
  localparam logic signed [OPW-1:0] K_COMP  = OPW'(COMP_F);
  localparam logic signed [OPW-1:0] K_WMAX  = OPW'(WMAX_F);
  localparam logic signed [OPW-1:0] K_VNOM  = OPW'(VNOM_F);
  localparam logic signed [OPW-1:0] K_TMR   = OPW'(TM_RECIP);

  localparam logic [63:0] SR6  = ONE_Q32 / 64'd6;
  localparam logic [63:0] SR20 = ONE_Q32 / 64'd20;
  localparam logic [63:0] SR42 = ONE_Q32 / 64'd42;
  localparam logic [63:0] SR72 = ONE_Q32 / 64'd72;

  typedef struct packed {
    logic [1:0]         loop_mode;
    logic signed [26:0] p_set;
    logic signed [26:0] q_set;
    logic [30:0]        dp;
    logic [30:0]        ki;
    logic [30:0]        inv_j;
    logic [30:0]        inv_k;
    logic [30:0]        dq;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] emf;
    logic [18:0]        angle;
    logic [25:0]        speed;
    logic signed [31:0] torque;
    logic signed [31:0] reactive;
    logic signed [31:0] field;
  } res_t;

  typedef enum logic [2:0] {
    RG_LOOP_MODE, RG_P_SET, RG_Q_SET, RG_DAMP, RG_REF_KI, RG_INV_J, RG_INV_K, RG_DROOP
  } reg_idx_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  typedef enum logic [4:0] {
    SP_SIN_OLD, SP_IMAG, SP_TRAW, SP_TF_OLD, SP_TF_NEW, SP_DAMP, SP_KI, SP_SINT,
    SP_TM_EST, SP_TM_FIX, SP_ACC, SP_SPEED, SP_ANGLE, SP_COS, SP_QFI, SP_QFW,
    SP_QRAW, SP_QF_OLD, SP_QF_NEW, SP_DROOP, SP_KQ, SP_FIELD, SP_SIN_NEW,
    SP_EMF_FW, SP_EMF
  } step_t;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -70'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // series divisors 6, 20, 42, 72 by term number
  function automatic logic [6:0] sin_div(input logic [2:0] k);
    case (k)
      3'd1:    return 7'd6;
      3'd2:    return 7'd20;
      3'd3:    return 7'd42;
      default: return 7'd72;
    endcase
  endfunction

  function automatic logic signed [OPW-1:0] sin_recip(input logic [2:0] k);
    case (k)
      3'd1:    return OPW'(SR6);
      3'd2:    return OPW'(SR20);
      3'd3:    return OPW'(SR42);
      default: return OPW'(SR72);
    endcase
  endfunction

endpackage

### hdl/synchronverter_control_step_top.sv
// synchronverter control step: an accepted item runs through the sequencer to out_tvalid
// a new item is taken only once the core is idle again; all steps share the single 34x34 multiplier
// (three sine series plus 22 multiply steps, each with an issue and a writeback phase, then done and idle)
// the result sits in an output register, so the next item is taken while it waits
// rst_n synchronous active low: config to defaults, rotor at nominal speed, angle zero
module synchronverter_control_step_top (
  input  logic          clk,
  input  logic          rst_n,
  // config write port
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [30:0]   cfg_wdata,
  // input items
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,    // current_sample[22:0], grid_rms_voltage[45:23]
  // result items
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [175:0]  out_tdata    // emf_out[31:0], angle_out[50:32], speed_out[76:51],
                                     // torque_out[108:77], reactive_out[140:109],
                                     // field_out[172:141]
);

  scs_pkg::cfg_t cfg_r, cfg_nxt;
  scs_pkg::res_t res_c, out_res_r;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          core_idle, res_valid, res_ready;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (scs_pkg::reg_idx_t'(cfg_index))
        scs_pkg::RG_LOOP_MODE: cfg_nxt.loop_mode = cfg_wdata[1:0];
        scs_pkg::RG_P_SET:     cfg_nxt.p_set     = signed'(cfg_wdata[26:0]);
        scs_pkg::RG_Q_SET:     cfg_nxt.q_set     = signed'(cfg_wdata[26:0]);
        scs_pkg::RG_DAMP:      cfg_nxt.dp        = cfg_wdata;
        scs_pkg::RG_REF_KI:    cfg_nxt.ki        = cfg_wdata;
        scs_pkg::RG_INV_J:     cfg_nxt.inv_j     = cfg_wdata;
        scs_pkg::RG_INV_K:     cfg_nxt.inv_k     = cfg_wdata;
        scs_pkg::RG_DROOP:     cfg_nxt.dq        = cfg_wdata;
        default:               cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_mode <= 2'd0;
      cfg_r.p_set     <= 27'sd0;
      cfg_r.q_set     <= 27'sd0;
      cfg_r.dp        <= 31'd0;
      cfg_r.ki        <= 31'd0;
      cfg_r.inv_j     <= 31'd0;
      cfg_r.inv_k     <= 31'd0;
      cfg_r.dq        <= 31'(scs_pkg::DQ_F);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer and loop state
  scs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .start_i     (in_tvalid),
    .cur_i       (signed'(in_tdata[22:0])),
    .vg_i        (in_tdata[45:23]),
    .idle_o      (core_idle),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res_c)
  );

  assign in_tready = core_idle;

  // output register: free when empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_res_r.field, out_res_r.reactive, out_res_r.torque,
                       out_res_r.speed, out_res_r.angle, out_res_r.emf};

endmodule

### hdl/scs_mul.sv
// shared signed multiplier with registered product
module scs_mul (
  input  logic                               clk,
  input  logic signed [scs_pkg::OPW-1:0]     a_i,
  input  logic signed [scs_pkg::OPW-1:0]     b_i,
  output logic signed [scs_pkg::PRW-1:0]     prod_o
);

  logic signed [scs_pkg::PRW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
  end

  assign prod_o = prod_r;

endmodule

### hdl/scs_core.sv
// sequencer, loop state and post-processing around the shared multiplier
module scs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  scs_pkg::cfg_t       cfg_i,
  input  logic                start_i,
  input  logic signed [22:0]  cur_i,
  input  logic [22:0]         vg_i,
  output logic                idle_o,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output scs_pkg::res_t       res_o
);

  localparam int OPW = scs_pkg::OPW;
  localparam int PRW = scs_pkg::PRW;

  scs_pkg::state_t state_r, state_nxt;
  scs_pkg::step_t  step_r, step_nxt;
  logic [3:0]      sub_r, sub_nxt;
  logic            ph_r, ph_nxt;

  // loop state
  logic [18:0]        ang_r, ang_nxt;
  logic [25:0]        spd_r, spd_nxt;
  logic signed [31:0] sref_r, sref_nxt;
  logic signed [31:0] sint_r, sint_nxt;
  logic signed [31:0] tf_r, tf_nxt;
  logic signed [31:0] qf_r, qf_nxt;
  logic signed [31:0] fint_r, fint_nxt;

  // work registers
  logic signed [22:0] cur_r, cur_nxt;
  logic [22:0]        vg_r, vg_nxt;
  logic signed [31:0] t1_r, t1_nxt;
  logic signed [31:0] t2_r, t2_nxt;
  logic signed [31:0] damp_r, damp_nxt;
  logic signed [31:0] tm_r, tm_nxt;
  logic signed [31:0] emf_r, emf_nxt;
  logic signed [31:0] sin_r, sin_nxt;
  logic [17:0]        tq_r, tq_nxt;
  logic [31:0]        x2_r, x2_nxt;
  logic [31:0]        p_r, p_nxt;
  logic [30:0]        term_r, term_nxt;
  logic signed [32:0] sum_r, sum_nxt;
  logic               neg_r, neg_nxt;

  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PRW-1:0] prod;

  logic signed [31:0]  field_c, p16_c, p30_c;
  logic signed [33:0]  p32_c, spd_s, w_c, ang_w;
  logic signed [69:0]  wide_c;
  logic signed [31:0]  qsum0_c, qsum_c, sint_c;
  logic                is_sin;
  logic [33:0]         x_c, xf_c;
  logic [30:0]         ux_c;
  logic                xneg_c;
  logic [6:0]          sd_c;
  logic [31:0]         q0_c;
  logic [39:0]         qd_c, r_c;
  logic [30:0]         q_c;
  logic signed [32:0]  sum_new_c;
  logic signed [31:0]  sin_fin_c;
  logic [26:0]         pabs_c;
  logic [43:0]         tm_r_c;
  logic [18:0]         tq_fix_c;

  scs_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // common views of the product
  assign p16_c  = scs_pkg::sat32(70'(prod >>> 16));
  assign p30_c  = scs_pkg::sat32(70'(prod >>> 30));
  assign p32_c  = 34'(prod >>> 32);
  assign field_c = scs_pkg::sat32(70'(fint_r) + 70'(scs_pkg::K_COMP));
  assign spd_s  = signed'(34'(spd_r));
  assign is_sin = (step_r == scs_pkg::SP_SIN_OLD) || (step_r == scs_pkg::SP_COS) ||
                  (step_r == scs_pkg::SP_SIN_NEW);

  // angle with 30 fraction bits, folded to a quarter wave
  always_comb begin
    x_c = (34'(ang_r) << scs_pkg::ANG_SH) +
          ((step_r == scs_pkg::SP_COS) ? 34'(scs_pkg::HALFPI_Q30) : 34'd0);
    if (x_c >= 34'(scs_pkg::TWOPI_Q30)) begin
      x_c = x_c - 34'(scs_pkg::TWOPI_Q30);
    end
    xneg_c = 1'b0;
    xf_c   = x_c;
    if (xf_c >= 34'(scs_pkg::PI_Q30)) begin
      xf_c   = xf_c - 34'(scs_pkg::PI_Q30);
      xneg_c = 1'b1;
    end
    if (xf_c > 34'(scs_pkg::HALFPI_Q30)) begin
      xf_c = 34'(scs_pkg::PI_Q30) - xf_c;
    end
    ux_c = xf_c[30:0];
  end

  // series term divide: reciprocal estimate, then up to two corrections
  always_comb begin
    sd_c = scs_pkg::sin_div(sub_r[3:1]);
    q0_c = prod[63:32];
    qd_c = 40'(q0_c) * 40'(sd_c);
    r_c  = 40'(p_r) - qd_c;
    if (r_c >= 40'({sd_c, 1'b0})) begin
      q_c = 31'(q0_c) + 31'd2;
    end else if (r_c >= 40'(sd_c)) begin
      q_c = 31'(q0_c) + 31'd1;
    end else begin
      q_c = 31'(q0_c);
    end
    sum_new_c = sub_r[1] ? sum_r - 33'(q_c) : sum_r + 33'(q_c);
    if (sum_new_c > 33'sd1073741824) begin
      sin_fin_c = 32'sd1073741824;
    end else if (sum_new_c < 33'sd0) begin
      sin_fin_c = 32'sd0;
    end else begin
      sin_fin_c = sum_new_c[31:0];
    end
    if (neg_r) begin
      sin_fin_c = -sin_fin_c;
    end
  end

  // mechanical torque quotient, reactive error and the integrator, speed and angle sums
  always_comb begin
    pabs_c   = cfg_i.p_set[26] ? 27'(-cfg_i.p_set) : 27'(cfg_i.p_set);
    tm_r_c   = (44'(pabs_c) << scs_pkg::FRAC_BITS) - prod[43:0];
    tq_fix_c = 19'(tq_r) + ((tm_r_c >= 44'(scs_pkg::WN_F)) ? 19'd1 : 19'd0);
    qsum0_c  = scs_pkg::sat32(70'(cfg_i.q_set) - 70'(qf_r));
    qsum_c   = cfg_i.loop_mode[1] ? scs_pkg::sat32(70'(qsum0_c) + 70'(t2_r)) : qsum0_c;
    sint_c   = scs_pkg::sat32(70'(sint_r) + 70'(p32_c));
    w_c      = spd_s + p32_c;
    ang_w    = signed'(34'(ang_r)) + p32_c;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sub_nxt   = sub_r;
    ph_nxt    = ph_r;
    ang_nxt   = ang_r;
    spd_nxt   = spd_r;
    sref_nxt  = sref_r;
    sint_nxt  = sint_r;
    tf_nxt    = tf_r;
    qf_nxt    = qf_r;
    fint_nxt  = fint_r;
    cur_nxt   = cur_r;
    vg_nxt    = vg_r;
    t1_nxt    = t1_r;
    t2_nxt    = t2_r;
    damp_nxt  = damp_r;
    tm_nxt    = tm_r;
    emf_nxt   = emf_r;
    sin_nxt   = sin_r;
    tq_nxt    = tq_r;
    x2_nxt    = x2_r;
    p_nxt     = p_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    neg_nxt   = neg_r;
    mul_a     = '0;
    mul_b     = '0;
    wide_c    = '0;

    case (state_r)
      scs_pkg::ST_IDLE: begin
        if (start_i) begin
          cur_nxt   = cur_i;
          vg_nxt    = vg_i;
          step_nxt  = scs_pkg::SP_SIN_OLD;
          sub_nxt   = 4'd0;
          ph_nxt    = 1'b0;
          state_nxt = scs_pkg::ST_RUN;
        end
      end

      scs_pkg::ST_RUN: begin
        // advance: issue phase, then writeback phase
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (is_sin && sub_r != 4'd8) begin
            sub_nxt = sub_r + 4'd1;
          end else begin
            sub_nxt = 4'd0;
            if (step_r == scs_pkg::SP_EMF) begin
              state_nxt = scs_pkg::ST_DONE;
            end else begin
              step_nxt = scs_pkg::step_t'(step_r + 5'd1);
            end
          end
        end

        if (is_sin) begin
          // sine series on the shared multiplier
          if (!ph_r) begin
            if (sub_r == 4'd0) begin
              mul_a = OPW'(ux_c);
              mul_b = OPW'(ux_c);
            end else if (sub_r[0]) begin
              mul_a = OPW'(term_r);
              mul_b = OPW'(x2_r);
            end else begin
              mul_a = OPW'(p_r);
              mul_b = scs_pkg::sin_recip(sub_r[3:1]);
            end
          end else begin
            if (sub_r == 4'd0) begin
              x2_nxt   = prod[61:30];
              term_nxt = ux_c;
              sum_nxt  = 33'(ux_c);
              neg_nxt  = xneg_c;
            end else if (sub_r[0]) begin
              p_nxt = prod[61:30];
            end else begin
              term_nxt = q_c;
              sum_nxt  = sum_new_c;
              if (sub_r == 4'd8) begin
                sin_nxt = sin_fin_c;
              end
            end
          end
        end else begin
          case (step_r)
            scs_pkg::SP_IMAG: begin
              mul_a = OPW'(cur_r);
              mul_b = OPW'(field_c);
              if (ph_r) t1_nxt = p16_c;
            end
            scs_pkg::SP_TRAW: begin
              mul_a = OPW'(t1_r);
              mul_b = OPW'(sin_r);
              if (ph_r) t1_nxt = p30_c;
            end
            scs_pkg::SP_TF_OLD: begin
              mul_a = OPW'(tf_r);
              mul_b = scs_pkg::K_APC;
              if (ph_r) t2_nxt = p32_c[31:0];
            end
            scs_pkg::SP_TF_NEW: begin
              mul_a = OPW'(t1_r);
              mul_b = scs_pkg::K_AP;
              if (ph_r) tf_nxt = scs_pkg::sat32(70'(t2_r) + 70'(p32_c));
            end
            scs_pkg::SP_DAMP: begin
              // speed error against nominal (droop) or reference (set)
              mul_a = OPW'(cfg_i.dp);
              wide_c = cfg_i.loop_mode[0] ? 70'(spd_s) - 70'(scs_pkg::K_WN)
                                          : 70'(spd_s) - 70'(sref_r);
              mul_b = OPW'(scs_pkg::sat32(wide_c));
              if (ph_r) damp_nxt = p16_c;
            end
            scs_pkg::SP_KI: begin
              mul_a = OPW'(cfg_i.ki);
              mul_b = OPW'(damp_r);
              if (ph_r) t2_nxt = p16_c;
            end
            scs_pkg::SP_SINT: begin
              mul_a = OPW'(t2_r);
              mul_b = scs_pkg::K_T;
              if (ph_r && !cfg_i.loop_mode[0]) begin
                sint_nxt = sint_c;
                sref_nxt = scs_pkg::sat32(70'(scs_pkg::K_WN) + 70'(sint_c));
              end
            end
            scs_pkg::SP_TM_EST: begin
              mul_a = OPW'(pabs_c);
              mul_b = scs_pkg::K_TMR;
              if (ph_r) tq_nxt = prod[scs_pkg::TM_SH+17:scs_pkg::TM_SH];
            end
            scs_pkg::SP_TM_FIX: begin
              mul_a = OPW'(tq_r);
              mul_b = scs_pkg::K_WN;
              if (ph_r) begin
                tm_nxt = cfg_i.p_set[26] ? -32'(tq_fix_c) : 32'(tq_fix_c);
              end
            end
            scs_pkg::SP_ACC: begin
              mul_a = OPW'(cfg_i.inv_j);
              wide_c = 70'(tm_r) - 70'(damp_r) - 70'(tf_r);
              mul_b = OPW'(scs_pkg::sat32(wide_c));
              if (ph_r) t2_nxt = p16_c;
            end
            scs_pkg::SP_SPEED: begin
              mul_a = OPW'(t2_r);
              mul_b = scs_pkg::K_T;
              if (ph_r) begin
                if (w_c > scs_pkg::K_WMAX) begin
                  spd_nxt = 26'(scs_pkg::K_WMAX);
                end else if (w_c < 34'sd0) begin
                  spd_nxt = 26'd0;
                end else begin
                  spd_nxt = w_c[25:0];
                end
              end
            end
            scs_pkg::SP_ANGLE: begin
              mul_a = spd_s;
              mul_b = scs_pkg::K_T;
              if (ph_r) begin
                if (ang_w >= scs_pkg::K_TWOPI) begin
                  ang_nxt = 19'(ang_w - scs_pkg::K_TWOPI);
                end else begin
                  ang_nxt = ang_w[18:0];
                end
              end
            end
            scs_pkg::SP_QFI: begin
              mul_a = OPW'(field_c);
              mul_b = OPW'(cur_r);
              if (ph_r) t1_nxt = p16_c;
            end
            scs_pkg::SP_QFW: begin
              mul_a = OPW'(t1_r);
              mul_b = spd_s;
              if (ph_r) t1_nxt = p16_c;
            end
            scs_pkg::SP_QRAW: begin
              mul_a = OPW'(t1_r);
              mul_b = OPW'(sin_r);
              if (ph_r) t1_nxt = scs_pkg::sat32(-70'(p30_c));
            end
            scs_pkg::SP_QF_OLD: begin
              mul_a = OPW'(qf_r);
              mul_b = scs_pkg::K_AQC;
              if (ph_r) t2_nxt = p32_c[31:0];
            end
            scs_pkg::SP_QF_NEW: begin
              mul_a = OPW'(t1_r);
              mul_b = scs_pkg::K_AQ;
              if (ph_r) qf_nxt = scs_pkg::sat32(70'(t2_r) + 70'(p32_c));
            end
            scs_pkg::SP_DROOP: begin
              mul_a = OPW'(cfg_i.dq);
              mul_b = scs_pkg::K_VNOM - OPW'(vg_r);
              if (ph_r) t2_nxt = p16_c;
            end
            scs_pkg::SP_KQ: begin
              mul_a = OPW'(cfg_i.inv_k);
              mul_b = OPW'(qsum_c);
              if (ph_r) t2_nxt = p16_c;
            end
            scs_pkg::SP_FIELD: begin
              mul_a = OPW'(t2_r);
              mul_b = scs_pkg::K_T;
              if (ph_r) fint_nxt = scs_pkg::sat32(70'(fint_r) + 70'(p32_c));
            end
            scs_pkg::SP_EMF_FW: begin
              mul_a = OPW'(field_c);
              mul_b = spd_s;
              if (ph_r) t1_nxt = p16_c;
            end
            scs_pkg::SP_EMF: begin
              mul_a = OPW'(t1_r);
              mul_b = OPW'(sin_r);
              if (ph_r) emf_nxt = p30_c;
            end
            default: begin
              mul_a = '0;
              mul_b = '0;
            end
          endcase
        end
      end

      scs_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_nxt = scs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = scs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scs_pkg::ST_IDLE;
      step_r  <= scs_pkg::SP_SIN_OLD;
      sub_r   <= 4'd0;
      ph_r    <= 1'b0;
      ang_r   <= 19'd0;
      spd_r   <= 26'(scs_pkg::K_WN);
      sref_r  <= 32'(scs_pkg::K_WN);
      sint_r  <= 32'sd0;
      tf_r    <= 32'sd0;
      qf_r    <= 32'sd0;
      fint_r  <= 32'sd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sub_r   <= sub_nxt;
      ph_r    <= ph_nxt;
      ang_r   <= ang_nxt;
      spd_r   <= spd_nxt;
      sref_r  <= sref_nxt;
      sint_r  <= sint_nxt;
      tf_r    <= tf_nxt;
      qf_r    <= qf_nxt;
      fint_r  <= fint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    vg_r   <= vg_nxt;
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    damp_r <= damp_nxt;
    tm_r   <= tm_nxt;
    emf_r  <= emf_nxt;
    sin_r  <= sin_nxt;
    tq_r   <= tq_nxt;
    x2_r   <= x2_nxt;
    p_r    <= p_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    neg_r  <= neg_nxt;
  end

  assign idle_o         = (state_r == scs_pkg::ST_IDLE);
  assign res_valid_o    = (state_r == scs_pkg::ST_DONE);
  assign res_o.emf      = emf_r;
  assign res_o.angle    = ang_r;
  assign res_o.speed    = spd_r;
  assign res_o.torque   = tf_r;
  assign res_o.reactive = qf_r;
  assign res_o.field    = field_c;

endmodule
